// ----- rtl/tbe_pkg.sv -----
// shared types and constants of the transparent blit engine
package tbe_pkg;

    // coordinate width actually used out of each 16-bit field (8 to 16)
    localparam int COORD_BITS = 16;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS:0]   coord_ext_t;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE           = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEST_RECT      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SRC_RECT       = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_SIZE    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERRIDE_COLOR = 3'd4;

    // blit modes
    localparam logic [1:0] MODE_COPY     = 2'd0;
    localparam logic [1:0] MODE_OVERRIDE = 2'd1;
    localparam logic [1:0] MODE_MIRROR_X = 2'd2;
    localparam logic [1:0] MODE_MIRROR_Y = 2'd3;

    // request kinds
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    // stream widths
    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 104;

    // one result, done flag travels as tlast
    typedef struct packed {
        logic        fetch_valid;
        logic [15:0] fetch_x;
        logic [15:0] fetch_y;
        logic        write_valid;
        logic [31:0] write_addr;
        logic [31:0] write_data;
        logic        done_res;
    } result_t;

endpackage

// ----- rtl/transparent_blit_engine.sv -----
// transparent blit engine: copy, override-color copy and mirror passes with alpha key
//
// A start request (tuser = 0) begins a pass and is answered with the first coordinate to
// fetch, or with tlast and no fetch if the area is empty. Each pixel request (tuser = 1)
// returns the fetched color; the result carries a framebuffer write when alpha is nonzero,
// plus the next fetch coordinate, or tlast when the pass is over. Exactly one result comes
// back per request. The block takes one request per clock cycle and keeps doing so while
// results flow out; a taken request is held in the input register and its result in the
// result register, where it waits until it is accepted.
// The rate is set by the position counters, which step once per request, combinationally
// next to one 32x32 multiply-add for the write address. Configuration registers are read
// live and should be written while no request is in flight.
module transparent_blit_engine
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [tbe_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [63:0]                         cfg_data,
    // request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tbe_pkg::IN_DATA_BITS-1:0]    s_tdata,   // pixel[31:0]
    input  logic [0:0]                          s_tuser,   // action[0]
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // fetch_valid[0], fetch_x[16:1], fetch_y[32:17], write_valid[33],
    // write_addr[65:34], write_data[97:66], zero pad[103:98]
    output logic [tbe_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    output logic                                m_tlast    // done_res
);

    // configuration
    logic [1:0]  mode_reg;
    logic [63:0] dest_rect_reg;
    logic [63:0] src_rect_reg;
    logic [31:0] screen_size_reg;
    logic [31:0] override_color_reg;

    // input register
    logic        in_valid_reg;
    logic        in_action_reg;
    logic [31:0] in_pixel_reg;

    // pass state
    logic             busy_reg, busy_next;
    tbe_pkg::coord_t  dest_x_reg, dest_x_next;
    tbe_pkg::coord_t  dest_y_reg, dest_y_next;
    tbe_pkg::coord_t  source_x_reg, source_x_next;
    tbe_pkg::coord_t  source_y_reg, source_y_next;

    // result register
    logic              out_valid_reg;
    tbe_pkg::result_t  out_reg;
    tbe_pkg::result_t  res_next;

    logic advance;

    // register fields
    tbe_pkg::coord_t dx0, dy0, dx1, dy1, sx0, sy0, sx1, sy1, scr_w, scr_h;
    tbe_pkg::coord_t xlim, ylim;
    logic            copy_mode;
    logic            more;
    logic            opaque;
    logic [31:0]     wx, wy, pitch, wy_scaled;
    tbe_pkg::coord_ext_t inc_dx, inc_dy, inc_sx, inc_sy;

    assign dx0   = dest_rect_reg[tbe_pkg::COORD_BITS-1:0];
    assign dy0   = dest_rect_reg[16 +: tbe_pkg::COORD_BITS];
    assign dx1   = dest_rect_reg[32 +: tbe_pkg::COORD_BITS];
    assign dy1   = dest_rect_reg[48 +: tbe_pkg::COORD_BITS];
    assign sx0   = src_rect_reg[tbe_pkg::COORD_BITS-1:0];
    assign sy0   = src_rect_reg[16 +: tbe_pkg::COORD_BITS];
    assign sx1   = src_rect_reg[32 +: tbe_pkg::COORD_BITS];
    assign sy1   = src_rect_reg[48 +: tbe_pkg::COORD_BITS];
    assign scr_w = screen_size_reg[tbe_pkg::COORD_BITS-1:0];
    assign scr_h = screen_size_reg[16 +: tbe_pkg::COORD_BITS];

    assign xlim = (dx1 < scr_w) ? dx1 : scr_w;
    assign ylim = (dy1 < scr_h) ? dy1 : scr_h;

    assign copy_mode = (mode_reg == tbe_pkg::MODE_COPY) || (mode_reg == tbe_pkg::MODE_OVERRIDE);
    assign opaque    = (in_pixel_reg[31:24] != 8'd0);

    assign inc_dx = {1'b0, dest_x_reg} + 1'b1;
    assign inc_dy = {1'b0, dest_y_reg} + 1'b1;
    assign inc_sx = {1'b0, source_x_reg} + 1'b1;
    assign inc_sy = {1'b0, source_y_reg} + 1'b1;

    // write target, wrapping to 32 bits in the mirror modes
    always_comb
    begin
        unique case (mode_reg)
            tbe_pkg::MODE_MIRROR_X:
            begin
                wx = 32'({dx1, 1'b0}) - 32'd1 - 32'(source_x_reg);
                wy = 32'(source_y_reg);
            end
            tbe_pkg::MODE_MIRROR_Y:
            begin
                wx = 32'(source_x_reg);
                wy = 32'({dy1, 1'b0}) - 32'd1 - 32'(source_y_reg);
            end
            default:
            begin
                wx = 32'(dest_x_reg);
                wy = 32'(dest_y_reg);
            end
        endcase
    end

    assign pitch     = 32'(scr_w);
    assign wy_scaled = wy * pitch;

    // per-request step of the pass
    always_comb
    begin
        busy_next     = busy_reg;
        dest_x_next   = dest_x_reg;
        dest_y_next   = dest_y_reg;
        source_x_next = source_x_reg;
        source_y_next = source_y_reg;
        more          = 1'b0;
        res_next      = '0;

        if (in_action_reg == tbe_pkg::ACT_START)
        begin
            if (copy_mode)
            begin
                if (dx0 < xlim && dy0 < ylim)
                begin
                    more          = 1'b1;
                    dest_x_next   = dx0;
                    dest_y_next   = dy0;
                    source_x_next = sx0;
                    source_y_next = sy0;
                end
            end
            else if (dx0 < dx1 && dy0 < dy1)
            begin
                more          = 1'b1;
                source_x_next = dx0;
                source_y_next = dy0;
                dest_x_next   = dx0;
                dest_y_next   = dy0;
            end
        end
        else if (busy_reg)
        begin
            if (opaque)
            begin
                res_next.write_valid = 1'b1;
                res_next.write_addr  = wx + wy_scaled;
                res_next.write_data  = (mode_reg == tbe_pkg::MODE_OVERRIDE) ?
                                       override_color_reg : in_pixel_reg;
            end
            if (copy_mode)
            begin
                if (inc_dx < {1'b0, xlim})
                begin
                    more          = 1'b1;
                    dest_x_next   = inc_dx[tbe_pkg::COORD_BITS-1:0];
                    source_x_next = (inc_sx >= {1'b0, sx1}) ?
                                    sx0 : inc_sx[tbe_pkg::COORD_BITS-1:0];
                end
                else if (inc_dy < {1'b0, ylim} && dx0 < xlim)
                begin
                    more          = 1'b1;
                    dest_y_next   = inc_dy[tbe_pkg::COORD_BITS-1:0];
                    source_y_next = (inc_sy >= {1'b0, sy1}) ?
                                    sy0 : inc_sy[tbe_pkg::COORD_BITS-1:0];
                    dest_x_next   = dx0;
                    source_x_next = sx0;
                end
            end
            else
            begin
                if (inc_sx < {1'b0, dx1})
                begin
                    more          = 1'b1;
                    source_x_next = inc_sx[tbe_pkg::COORD_BITS-1:0];
                    dest_x_next   = inc_sx[tbe_pkg::COORD_BITS-1:0];
                    dest_y_next   = source_y_reg;
                end
                else if (inc_sy < {1'b0, dy1})
                begin
                    more          = 1'b1;
                    source_y_next = inc_sy[tbe_pkg::COORD_BITS-1:0];
                    source_x_next = dx0;
                    dest_y_next   = inc_sy[tbe_pkg::COORD_BITS-1:0];
                    dest_x_next   = dx0;
                end
            end
        end

        // a pixel while idle leaves everything as is and answers all zeros
        if (in_action_reg == tbe_pkg::ACT_START || busy_reg)
        begin
            busy_next = more;
            if (more)
            begin
                res_next.fetch_valid = 1'b1;
                res_next.fetch_x     = 16'(source_x_next);
                res_next.fetch_y     = 16'(source_y_next);
            end
            else
            begin
                res_next.done_res = 1'b1;
            end
        end
    end

    // the held request moves on when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= tbe_pkg::MODE_COPY;
            dest_rect_reg      <= '0;
            src_rect_reg       <= '0;
            screen_size_reg    <= '0;
            override_color_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbe_pkg::CFG_MODE:           mode_reg           <= cfg_data[1:0];
                tbe_pkg::CFG_DEST_RECT:      dest_rect_reg      <= cfg_data;
                tbe_pkg::CFG_SRC_RECT:       src_rect_reg       <= cfg_data;
                tbe_pkg::CFG_SCREEN_SIZE:    screen_size_reg    <= cfg_data[31:0];
                tbe_pkg::CFG_OVERRIDE_COLOR: override_color_reg <= cfg_data[31:0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_action_reg <= s_tuser[0];
            in_pixel_reg  <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            dest_x_reg   <= '0;
            dest_y_reg   <= '0;
            source_x_reg <= '0;
            source_y_reg <= '0;
        end
        else if (advance)
        begin
            busy_reg     <= busy_next;
            dest_x_reg   <= dest_x_next;
            dest_y_reg   <= dest_y_next;
            source_x_reg <= source_x_next;
            source_y_reg <= source_y_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.done_res;
    assign m_tdata  = {6'd0, out_reg.write_data, out_reg.write_addr, out_reg.write_valid,
                       out_reg.fetch_y, out_reg.fetch_x, out_reg.fetch_valid};

    // a result never both asks for a fetch and ends the pass
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.fetch_valid && out_reg.done_res))
        else $error("result carries fetch and done together");

    // after a step the pass is running exactly when that result asked for a fetch
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (busy_reg == out_reg.fetch_valid))
        else $error("busy flag disagrees with fetch request");

    // a start request never produces a framebuffer write
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_action_reg == tbe_pkg::ACT_START) |=> !out_reg.write_valid)
        else $error("write issued for a start request");

    // a held request is not lost or overwritten while the result side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_pixel_reg)))
        else $error("held request dropped");

    // a write only comes from a running pass, so it ends or continues it
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.write_valid) |-> (out_reg.fetch_valid || out_reg.done_res))
        else $error("write outside a pass");

endmodule
